FILE: hdl/gdfw_pkg.sv
// Package for the depth-first graph walk engine: sizes, action codes, status
// codes and the command struct passed from front end to back end. No dependencies.
package gdfw_pkg;
  localparam int NODE_COUNT = 16;
  localparam int MAX_DEGREE = 8;
  localparam int NW  = $clog2(NODE_COUNT);
  localparam int DW  = $clog2(MAX_DEGREE);
  localparam int CW  = $clog2(MAX_DEGREE + 1);
  localparam int SW  = $clog2(NODE_COUNT + 1);
  localparam int AW  = NW + DW;
  localparam int STORE_DEPTH = NODE_COUNT * MAX_DEGREE;
  localparam int QDEPTH = 2;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_WALK  = 2'd1;
  localparam logic [1:0] ACT_CLRV  = 2'd2;
  localparam logic [1:0] ACT_CLRG  = 2'd3;

  localparam logic [1:0] ST_NODE = 2'd0;
  localparam logic [1:0] ST_DONE = 2'd1;
  localparam logic [1:0] ST_DROP = 2'd2;

  typedef struct packed {
    logic [1:0]    action;
    logic [NW-1:0] node_a;
    logic [NW-1:0] node_b;
    logic          directed;
  } cmd_t;
endpackage

FILE: hdl/graph_depth_first_walk.sv
// Top level of the depth-first graph walk engine: front-end command queue
// and back-end walker. Depends on gdfw_pkg, gdfw_front, gdfw_back.
//
// Commands are taken while busy is low into a two-entry queue. When the back
// end is free, edge, clear and already-visited traverse commands answer one
// registered beat once read from the queue (an undirected add first passes
// S_ARC2). A traversal passes S_TOP, S_RD and S_CHK for each neighbour
// entry examined, S_RD covering the registered read of the neighbour RAM,
// and S_TOP per stack pop; each newly reached node is a beat in preorder,
// last on the final one. Result beats cannot be held off by the receiver.
module graph_depth_first_walk import gdfw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_action,
  input  logic [NW-1:0] in_node_a,
  input  logic [NW-1:0] in_node_b,
  input  logic          in_directed,
  output logic          out_valid,
  output logic [NW-1:0] out_node,
  output logic [1:0]    out_status,
  output logic          out_last
);
  logic pop, q_valid;
  cmd_t q_cmd;

  gdfw_front u_front (
    .clk, .rst_n, .start, .busy, .in_action, .in_node_a, .in_node_b,
    .in_directed, .pop, .q_valid, .q_cmd
  );

  gdfw_back u_back (
    .clk, .rst_n, .q_valid, .q_cmd, .pop, .out_valid, .out_node,
    .out_status, .out_last
  );
endmodule

FILE: hdl/gdfw_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module gdfw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: hdl/gdfw_front.sv
// Front end: takes commands and queues them for the back end.
// Depends on gdfw_pkg.
module gdfw_front import gdfw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  logic [1:0]    in_action,
  input  logic [NW-1:0] in_node_a,
  input  logic [NW-1:0] in_node_b,
  input  logic          in_directed,
  input  logic          pop,
  output logic          q_valid,
  output cmd_t          q_cmd
);
  localparam int QW = $clog2(QDEPTH);
  cmd_t             q_r [QDEPTH];
  logic [QW-1:0]    wp_r, rp_r;
  logic [QW:0]      cnt_r;
  logic             push;

  assign busy    = (cnt_r == (QW+1)'(QDEPTH));
  assign push    = start && !busy;
  assign q_valid = (cnt_r != '0);
  assign q_cmd   = q_r[rp_r];

  // payload store
  always_ff @(posedge clk) begin
    if (push) q_r[wp_r] <= '{in_action, in_node_a, in_node_b, in_directed};
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= wp_r + 1'b1;
      if (pop)  rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + (QW+1)'(push) - (QW+1)'(pop);
    end
  end
endmodule

FILE: hdl/gdfw_back.sv
// Back end: executes queued commands, owns degree counts, visited marks,
// the walk stack and the neighbour RAM. Depends on gdfw_pkg, gdfw_ram.
module gdfw_back import gdfw_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  cmd_t          q_cmd,
  output logic          pop,
  output logic          out_valid,
  output logic [NW-1:0] out_node,
  output logic [1:0]    out_status,
  output logic          out_last
);
  typedef enum logic [2:0] {
    S_IDLE, S_ARC2, S_TOP, S_RD, S_CHK, S_END
  } state_t;

  state_t          st_r;
  cmd_t            cmd_r;
  logic [CW-1:0]   deg_r [NODE_COUNT];
  logic            vis_r [NODE_COUNT];
  logic [NW-1:0]   stk_node_r [NODE_COUNT];
  logic [CW-1:0]   stk_pos_r  [NODE_COUNT];
  logic [SW-1:0]   sp_r;
  logic            drop_r;
  logic            we;
  logic [AW-1:0]   waddr, raddr;
  logic [NW-1:0]   wdata, rdata;
  logic [NW-1:0]   top_node;
  logic [CW-1:0]   top_pos;
  logic [NW-1:0]   tidx;

  assign tidx     = NW'(sp_r - 1'b1);
  assign top_node = stk_node_r[tidx];
  assign top_pos  = stk_pos_r[tidx];
  assign raddr    = {top_node, top_pos[DW-1:0]};

  // arc write for the first or second arc of an add
  always_comb begin
    we = 1'b0; waddr = '0; wdata = '0;
    if (st_r == S_IDLE && q_valid && q_cmd.action == ACT_ADD &&
        deg_r[q_cmd.node_a] != CW'(MAX_DEGREE)) begin
      we = 1'b1; waddr = {q_cmd.node_a, deg_r[q_cmd.node_a][DW-1:0]};
      wdata = q_cmd.node_b;
    end else if (st_r == S_ARC2 && deg_r[cmd_r.node_b] != CW'(MAX_DEGREE)) begin
      we = 1'b1; waddr = {cmd_r.node_b, deg_r[cmd_r.node_b][DW-1:0]};
      wdata = cmd_r.node_a;
    end
  end

  gdfw_ram #(.WIDTH(NW), .DEPTH(STORE_DEPTH)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  assign pop = (st_r == S_IDLE) && q_valid;

  // sequencer: state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; sp_r <= '0; out_valid <= 1'b0; drop_r <= 1'b0;
      for (int i = 0; i < NODE_COUNT; i++) begin
        deg_r[i] <= '0; vis_r[i] <= 1'b0;
      end
    end else begin
      out_valid <= 1'b0; out_node <= '0; out_status <= ST_DONE; out_last <= 1'b1;
      case (st_r)
        S_IDLE: if (q_valid) begin
          cmd_r <= q_cmd;
          case (q_cmd.action)
            ACT_ADD: begin
              if (we) deg_r[q_cmd.node_a] <= deg_r[q_cmd.node_a] + 1'b1;
              if (q_cmd.directed) begin
                out_valid <= 1'b1;
                out_status <= we ? ST_DONE : ST_DROP;
              end else begin
                drop_r <= !we; st_r <= S_ARC2;
              end
            end
            ACT_WALK: begin
              if (vis_r[q_cmd.node_a]) out_valid <= 1'b1;
              else begin
                vis_r[q_cmd.node_a] <= 1'b1;
                stk_node_r[0] <= q_cmd.node_a; stk_pos_r[0] <= '0;
                sp_r <= SW'(1); st_r <= S_TOP;
                // the start node is held back until we know if it is last
              end
            end
            ACT_CLRV: begin
              for (int i = 0; i < NODE_COUNT; i++) vis_r[i] <= 1'b0;
              out_valid <= 1'b1;
            end
            default: begin
              for (int i = 0; i < NODE_COUNT; i++) deg_r[i] <= '0;
              out_valid <= 1'b1;
            end
          endcase
        end
        S_ARC2: begin
          if (we) deg_r[cmd_r.node_b] <= deg_r[cmd_r.node_b] + 1'b1;
          out_valid <= 1'b1;
          out_status <= (drop_r || !we) ? ST_DROP : ST_DONE;
          st_r <= S_IDLE;
        end
        S_TOP: begin
          if (sp_r == '0) st_r <= S_END;
          else if (top_pos >= deg_r[top_node]) sp_r <= sp_r - 1'b1;
          else st_r <= S_RD;
        end
        S_RD: begin
          stk_pos_r[tidx] <= top_pos + 1'b1;
          st_r <= S_CHK;
        end
        S_CHK: begin
          st_r <= S_TOP;
          if (!vis_r[rdata] && sp_r < SW'(NODE_COUNT)) begin
            // emit the node pending from before, then hold this one
            out_valid <= 1'b1; out_status <= ST_NODE; out_last <= 1'b0;
            out_node <= cmd_r.node_a;
            cmd_r.node_a <= rdata;
            vis_r[rdata] <= 1'b1;
            stk_node_r[NW'(sp_r)] <= rdata; stk_pos_r[NW'(sp_r)] <= '0;
            sp_r <= sp_r + 1'b1;
          end
        end
        S_END: begin
          out_valid <= 1'b1; out_status <= ST_NODE; out_last <= 1'b1;
          out_node <= cmd_r.node_a;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

FILE: hdl/gdfw_checker.sv
// Port-level checker for the graph walk engine, bound to the top level.
// Depends on gdfw_pkg.
module gdfw_checker import gdfw_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          busy,
  input logic          out_valid,
  input logic [NW-1:0] out_node,
  input logic [1:0]    out_status,
  input logic          out_last
);
  // status codes stay in range
  a_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == ST_NODE || out_status == ST_DONE ||
                   out_status == ST_DROP))
    else $error("bad status");
  // non-node beats carry node zero and close the item
  a_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != ST_NODE) |-> (out_node == '0 && out_last))
    else $error("done beat malformed");
  // no result straight out of reset
  a_rst: assert property (@(posedge clk) $past(!rst_n) |-> !out_valid)
    else $error("beat after reset");
  // not busy straight after reset
  a_busy: assert property (@(posedge clk) $past(!rst_n) |-> !busy)
    else $error("busy after reset");
endmodule

bind graph_depth_first_walk gdfw_checker u_chk (.*);
